// File: hdl/logic_trigger_condition_matcher_unit_assert.svh
// Assertion macros for the trigger condition matcher.
`ifndef LOGIC_TRIGGER_CONDITION_MATCHER_UNIT_ASSERT_SVH
`define LOGIC_TRIGGER_CONDITION_MATCHER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define LTCM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Checked at every edge, reset included.
`define LTCM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/ltcm_pkg.sv
// Types and constants shared by the trigger condition matcher.
package ltcm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LANE_W    = 16;
  localparam int NUM_LANES = 4;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_MASKS   = 3'd0,
    CFG_LOW_MASKS    = 3'd1,
    CFG_CHANGE_MASKS = 3'd2,
    CFG_STEADY_MASKS = 3'd3,
    CFG_SKIP_COUNTS  = 3'd4,
    CFG_SKIP_ONLY    = 3'd5,
    CFG_INIT_PINS    = 3'd6,
    CFG_INIT_FIRST   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]     high_masks;
    logic [CFG_W-1:0]     low_masks;
    logic [CFG_W-1:0]     change_masks;
    logic [CFG_W-1:0]     steady_masks;
    logic [CFG_W-1:0]     skip_counts;
    logic [NUM_LANES-1:0] skip_only;
    logic [SAMPLE_W-1:0]  init_pins;
    logic [SAMPLE_W-1:0]  init_first;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic hit;
  } cond_res_t;

endpackage

// File: hdl/ltcm_if.sv
// Valid/ready channel interfaces for sample words and result words.
interface ltcm_in_if;
  logic                          valid;
  logic                          ready;
  logic [ltcm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ltcm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           matched;
  logic [ltcm_pkg::NUM_LANES-1:0] condition_hits;
  logic [ltcm_pkg::SAMPLE_W-1:0]  pins;

  modport source (output valid, output matched, output condition_hits, output pins,
                  input ready);
  modport sink   (input valid, input matched, input condition_hits, input pins,
                  output ready);
endinterface

// File: hdl/ltcm_cfg.sv
// Configuration register file of the trigger condition matcher.
module ltcm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ltcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ltcm_pkg::CFG_W-1:0]     cfg_data_i,
  output ltcm_pkg::cfg_t                 cfg_o
);

  ltcm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ltcm_pkg::cfg_idx_e'(cfg_idx_i))
        ltcm_pkg::CFG_HIGH_MASKS:   cfg_d.high_masks   = cfg_data_i;
        ltcm_pkg::CFG_LOW_MASKS:    cfg_d.low_masks    = cfg_data_i;
        ltcm_pkg::CFG_CHANGE_MASKS: cfg_d.change_masks = cfg_data_i;
        ltcm_pkg::CFG_STEADY_MASKS: cfg_d.steady_masks = cfg_data_i;
        ltcm_pkg::CFG_SKIP_COUNTS:  cfg_d.skip_counts  = cfg_data_i;
        ltcm_pkg::CFG_SKIP_ONLY:
          cfg_d.skip_only = cfg_data_i[ltcm_pkg::NUM_LANES-1:0];
        ltcm_pkg::CFG_INIT_PINS:
          cfg_d.init_pins = cfg_data_i[ltcm_pkg::SAMPLE_W-1:0];
        ltcm_pkg::CFG_INIT_FIRST:
          cfg_d.init_first = cfg_data_i[ltcm_pkg::SAMPLE_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/ltcm_cond.sv
// One trigger condition: pin level/toggle masks or a skip-only term.
module ltcm_cond #(
  parameter int CH_W   = 16,
  parameter int SKIP_W = 16
) (
  input  logic [CH_W-1:0]               cur_i,
  input  logic [CH_W-1:0]               chg_i,
  input  logic [CH_W-1:0]               high_i,
  input  logic [CH_W-1:0]               low_i,
  input  logic [CH_W-1:0]               change_i,
  input  logic [CH_W-1:0]               steady_i,
  input  logic [ltcm_pkg::LANE_W-1:0]   skip_lane_i,
  input  logic                          skip_only_i,
  input  logic [SKIP_W-1:0]             elapsed_i,
  output ltcm_pkg::cond_res_t           res_o
);

  // only the low min(SKIP_W, LANE_W) bits of a lane count
  localparam int SL = (SKIP_W < ltcm_pkg::LANE_W) ? SKIP_W : ltcm_pkg::LANE_W;

  logic [SKIP_W-1:0] thresh;
  logic              pin_hit;
  logic              any_mask;

  assign thresh   = SKIP_W'(skip_lane_i[SL-1:0]);
  assign any_mask = |(high_i | low_i | change_i | steady_i);
  assign pin_hit  = ((cur_i & high_i) == high_i) && ((~cur_i & low_i) == low_i) &&
                    ((chg_i & change_i) == change_i) && ((~chg_i & steady_i) == steady_i);

  always_comb begin
    if (skip_only_i) begin
      res_o.active = 1'b1;
      res_o.hit    = (elapsed_i >= thresh);
    end else begin
      res_o.active = any_mask;
      res_o.hit    = any_mask && pin_hit;
    end
  end

endmodule

// File: hdl/logic_trigger_condition_matcher_unit.sv
// Trigger condition matcher: one logic sample word in, one match word out.
//
// in_ch_i carries sample words (valid/ready, accepted when both are high);
// out_ch_o carries result words: matched, condition_hits and pins (the sample).
// Each sample is compared with the previous one to find toggled channels,
// then up to four conditions are tested against levels, toggles or the skip
// counter. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user writes it only while the block is idle, not enforced by the block.
// An accepted word waits in the sample register, moves into the result
// register once that is empty or being read, and is offered from then on.
// Throughput is one word per cycle unless the receiver stalls: the sample and
// result registers form a two-deep pipeline, and the running state (previous
// levels, first-sample flag, skip count) updates with the result register.
// When the receiver stalls the result holds; one more word may wait in the
// sample register, after which in_ch_i.ready drops.
// Reset clears the pipeline, the configuration and the running state; the
// next word accepted is treated as the first sample.
`include "logic_trigger_condition_matcher_unit_assert.svh"

module logic_trigger_condition_matcher_unit #(
  parameter int CHANNELS   = 16,
  parameter int CONDITIONS = 4,
  parameter int SKIP_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ltcm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ltcm_pkg::CFG_W-1:0]     cfg_data_i,
  ltcm_in_if.sink                        in_ch_i,
  ltcm_out_if.source                     out_ch_o
);

  localparam int CH_W = (CHANNELS < ltcm_pkg::SAMPLE_W) ? CHANNELS : ltcm_pkg::SAMPLE_W;
  localparam int LW   = ltcm_pkg::LANE_W;

  ltcm_pkg::cfg_t cfg;

  ltcm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sample register
  logic            s1_valid_q, s1_valid_d;
  logic [CH_W-1:0] s1_sample_q;
  logic            load, adv;

  // running state
  logic [CH_W-1:0]      prev_q;
  logic                 first_q;
  logic [SKIP_BITS-1:0] elapsed_q, elapsed_d;

  // result register
  logic                           out_valid_q, out_valid_d;
  logic                           matched_q;
  logic [ltcm_pkg::NUM_LANES-1:0] hits_q;
  logic [CH_W-1:0]                pins_q;

  assign adv  = s1_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !s1_valid_q || adv;
  assign load = in_ch_i.valid && in_ch_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // match logic on the registered sample
  logic [CH_W-1:0]                prev, chg;
  logic [SKIP_BITS-1:0]           elapsed_now;
  logic [ltcm_pkg::NUM_LANES-1:0] hits, active;
  logic                           matched;

  assign prev = first_q ? prev_q
              : ((cfg.init_pins[CH_W-1:0] & ~cfg.init_first[CH_W-1:0]) |
                 (s1_sample_q & cfg.init_first[CH_W-1:0]));
  assign chg  = s1_sample_q ^ prev;
  assign elapsed_now = (&elapsed_q) ? elapsed_q : elapsed_q + SKIP_BITS'(1);

  for (genvar c = 0; c < ltcm_pkg::NUM_LANES; c++) begin : g_cond
    if (c < CONDITIONS) begin : g_on
      ltcm_pkg::cond_res_t res;

      ltcm_cond #(
        .CH_W   (CH_W),
        .SKIP_W (SKIP_BITS)
      ) u_cond (
        .cur_i       (s1_sample_q),
        .chg_i       (chg),
        .high_i      (cfg.high_masks[c*LW +: CH_W]),
        .low_i       (cfg.low_masks[c*LW +: CH_W]),
        .change_i    (cfg.change_masks[c*LW +: CH_W]),
        .steady_i    (cfg.steady_masks[c*LW +: CH_W]),
        .skip_lane_i (cfg.skip_counts[c*LW +: LW]),
        .skip_only_i (cfg.skip_only[c]),
        .elapsed_i   (elapsed_now),
        .res_o       (res)
      );

      assign hits[c]   = res.hit;
      assign active[c] = res.active;
    end else begin : g_off
      assign hits[c]   = 1'b0;
      assign active[c] = 1'b0;
    end
  end

  assign matched   = !(|active) || (|hits);
  assign elapsed_d = matched ? '0 : elapsed_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      first_q     <= 1'b0;
      elapsed_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        prev_q    <= s1_sample_q;
        first_q   <= 1'b1;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_sample_q <= in_ch_i.sample[CH_W-1:0];
    end
    if (adv) begin
      matched_q <= matched;
      hits_q    <= hits;
      pins_q    <= s1_sample_q;
    end
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.matched        = matched_q;
  assign out_ch_o.condition_hits = hits_q;
  assign out_ch_o.pins           = ltcm_pkg::SAMPLE_W'(pins_q);

  `LTCM_ASSERT(a_match_clears_skip, clk_i, rst_ni, adv && matched |=> elapsed_q == '0, "skip count not cleared on match")
  `LTCM_ASSERT(a_prev_tracks, clk_i, rst_ni, adv |=> first_q && prev_q == $past(s1_sample_q), "previous levels not updated")
  `LTCM_ASSERT(a_stall_full, clk_i, rst_ni, !in_ch_i.ready |-> s1_valid_q && out_valid_q && !out_ch_o.ready, "input stalled with room in pipeline")
  `LTCM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !s1_valid_q && !out_valid_q && !first_q, "pipeline not empty in reset")

endmodule
